/* hdl/rat_pkg.sv */
package rat_pkg;

   // default table geometry
   localparam int ID_BITS_DEF    = 16;
   localparam int SCAN_FIRST_DEF = 10;
   localparam int SCAN_END_DEF   = 65533;

   // register indexes
   localparam logic [1:0] REG_INACTIVE_LIMIT  = 2'd0;
   localparam logic [1:0] REG_REAPPEAR_WINDOW = 2'd1;
   localparam logic [1:0] REG_REAPPEAR_COUNT  = 2'd2;

   // opcodes
   localparam logic OP_SIGHTING = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   // register reset values
   localparam logic [30:0] INACTIVE_LIMIT_RST  = 31'd1000;
   localparam logic [30:0] REAPPEAR_WINDOW_RST = 31'd1000;
   localparam logic [15:0] REAPPEAR_COUNT_RST  = 16'd3;

   // one table entry
   typedef struct packed {
      logic        active;
      logic [15:0] total;
      logic [15:0] dl;
      logic [15:0] ul;
      logic [31:0] last_tti;
      logic [31:0] first_tti;
   } entry_type;

   // tti minus stamp, signed view, past limit
   function automatic logic diff_greater(logic [31:0] a, logic [31:0] b, logic [30:0] lim);
      logic [31:0] d;
      d = a - b;
      return !d[31] && (d[30:0] > lim);
   endfunction

   // tti minus stamp, signed view, inside limit
   function automatic logic diff_less(logic [31:0] a, logic [31:0] b, logic [30:0] lim);
      logic [31:0] d;
      d = a - b;
      return d[31] || (d[30:0] < lim);
   endfunction

endpackage

/* hdl/rnti_activity_tracker_core.sv */
// Per-RNTI activity table held in one single-port-write, registered-read memory of
// 2^ID_BITS entries. After reset a clearing pass writes every entry once, with no
// item accepted. A sighting steps through read, modify-write, read of its own entry,
// read of the top-total entry and result. A tick walks the scan range one entry a
// cycle, aging and ranking as it goes. Memory accesses of one item are strictly
// ordered, one item at a time; the result sits in an output register and the next
// item may be accepted while it waits.
module rnti_activity_tracker_core #(
   parameter int ID_BITS    = rat_pkg::ID_BITS_DEF,
   parameter int SCAN_FIRST = rat_pkg::SCAN_FIRST_DEF,
   parameter int SCAN_END   = rat_pkg::SCAN_END_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,  // rnti[15:0], tti[47:16], is_downlink[48], zero fill
   input  logic         req_tuser,  // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // is_active, top_total_rnti, top_dl_rnti, top_ul_rnti,
                                    // active_count, top_total_count, own_dl_count,
                                    // own_ul_count, zero fill
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [30:0]  csr_wdata
);
   import rat_pkg::*;

   localparam int DEPTH     = 1 << ID_BITS;
   localparam int END_EFF   = (SCAN_END < DEPTH) ? SCAN_END : DEPTH;
   localparam bit SCAN_NONE = (SCAN_FIRST >= END_EFF);
   localparam logic [ID_BITS-1:0] SCAN_LO = ID_BITS'(SCAN_FIRST);
   localparam logic [ID_BITS-1:0] SCAN_HI = ID_BITS'(END_EFF - 1);
   localparam logic [ID_BITS-1:0] LAST_ID = ID_BITS'(DEPTH - 1);

   typedef enum logic [6:0] {
      ST_CLR   = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SIGHT = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_OWN   = 7'b0010000,
      ST_TOP   = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [30:0] inact_lim_ff, window_ff;
   logic [15:0] reap_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inact_lim_ff <= INACTIVE_LIMIT_RST;
         window_ff    <= REAPPEAR_WINDOW_RST;
         reap_cnt_ff  <= REAPPEAR_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_INACTIVE_LIMIT:  inact_lim_ff <= csr_wdata;
            REG_REAPPEAR_WINDOW: window_ff    <= csr_wdata;
            REG_REAPPEAR_COUNT:  reap_cnt_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // latched item
   logic               dl_ff;
   logic [ID_BITS-1:0] rnti_ff;
   logic [31:0]        tti_ff;

   // memory ports
   entry_type          mem [DEPTH];
   entry_type          rd_data_ff, wr_data;
   logic [ID_BITS-1:0] rd_addr, wr_addr;
   logic               wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // walk index (clearing pass and scan)
   logic [ID_BITS-1:0] idx_ff, idx_in;

   // statistics
   logic [15:0] top_t_ff, top_d_ff, top_u_ff, act_ff;
   logic [15:0] best_t_ff, best_d_ff, best_u_ff, cnt_ff;
   logic [15:0] id_t_ff, id_d_ff, id_u_ff;
   logic [15:0] best_t_in, best_d_in, best_u_in, cnt_in, id_t_in, id_d_in, id_u_in;

   // result capture
   logic        own_act_ff;
   logic [15:0] own_dl_ff, own_ul_ff;
   logic        rsp_valid_ff;
   logic [119:0] rsp_data_ff;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // sighting update
   entry_type sight_e;
   always_comb begin
      sight_e          = rd_data_ff;
      sight_e.last_tti = tti_ff;
      sight_e.total    = rd_data_ff.total + 16'd1;
      if (dl_ff) sight_e.dl = rd_data_ff.dl + 16'd1;
      else       sight_e.ul = rd_data_ff.ul + 16'd1;
      if (!rd_data_ff.active) begin
         if (rd_data_ff.first_tti == 32'd0) begin
            sight_e.first_tti = tti_ff;
         end else if (diff_less(tti_ff, rd_data_ff.first_tti, window_ff) &&
                      (sight_e.total > reap_cnt_ff)) begin
            sight_e.active = 1'b1;
         end
      end
   end

   // aging of the scanned entry
   entry_type aged_e;
   logic      aged_clr;
   always_comb begin
      if (rd_data_ff.active)
         aged_clr = diff_greater(tti_ff, rd_data_ff.last_tti, inact_lim_ff);
      else
         aged_clr = (rd_data_ff.total != 16'd0) &&
                    diff_greater(tti_ff, rd_data_ff.first_tti, window_ff);
      aged_e = aged_clr ? '0 : rd_data_ff;
   end

   // ranking, strict greater keeps the lowest rnti on ties
   always_comb begin
      best_t_in = best_t_ff; best_d_in = best_d_ff; best_u_in = best_u_ff;
      id_t_in   = id_t_ff;   id_d_in   = id_d_ff;   id_u_in   = id_u_ff;
      cnt_in    = cnt_ff + 16'(aged_e.active);
      if (aged_e.total > best_t_ff) begin best_t_in = aged_e.total; id_t_in = 16'(idx_ff); end
      if (aged_e.dl > best_d_ff)    begin best_d_in = aged_e.dl;    id_d_in = 16'(idx_ff); end
      if (aged_e.ul > best_u_ff)    begin best_u_in = aged_e.ul;    id_u_in = 16'(idx_ff); end
   end

   // sequencer and memory port selection
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rd_addr  = rnti_ff;
      wr_addr  = idx_ff;
      wr_data  = '0;
      wr_en    = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_ID) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            rd_addr = req_tdata[ID_BITS-1:0];
            if (req_tuser == OP_TICK) rd_addr = SCAN_LO;
            idx_in = SCAN_LO;
            if (accept) begin
               if (req_tuser == OP_SIGHTING) state_in = ST_SIGHT;
               else if (SCAN_NONE)           state_in = ST_OWN;
               else                          state_in = ST_SCAN;
            end
         end
         ST_SIGHT: begin
            wr_en    = 1'b1;
            wr_addr  = rnti_ff;
            wr_data  = sight_e;
            state_in = ST_OWN;
         end
         ST_SCAN: begin
            rd_addr = idx_ff + 1'b1;
            wr_en   = aged_clr;
            wr_addr = idx_ff;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == SCAN_HI) state_in = ST_OWN;
         end
         ST_OWN: begin
            rd_addr  = rnti_ff;
            state_in = ST_TOP;
         end
         ST_TOP: begin
            rd_addr  = top_t_ff[ID_BITS-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rd_addr = top_t_ff[ID_BITS-1:0];
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         top_t_ff     <= '0;
         top_d_ff     <= '0;
         top_u_ff     <= '0;
         act_ff       <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_FIN && state_in == ST_IDLE) rsp_valid_ff <= 1'b1;
         // commit statistics at the end of the scan, or an empty scan
         if (state_ff == ST_SCAN && idx_ff == SCAN_HI) begin
            top_t_ff <= id_t_in;
            top_d_ff <= id_d_in;
            top_u_ff <= id_u_in;
            act_ff   <= cnt_in;
         end else if (SCAN_NONE && accept && req_tuser == OP_TICK) begin
            top_t_ff <= '0;
            top_d_ff <= '0;
            top_u_ff <= '0;
            act_ff   <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         rnti_ff   <= req_tdata[ID_BITS-1:0];
         tti_ff    <= req_tdata[47:16];
         dl_ff     <= req_tdata[48];
         best_t_ff <= '0; best_d_ff <= '0; best_u_ff <= '0; cnt_ff <= '0;
         id_t_ff   <= '0; id_d_ff   <= '0; id_u_ff   <= '0;
      end else if (state_ff == ST_SCAN) begin
         best_t_ff <= best_t_in; best_d_ff <= best_d_in; best_u_ff <= best_u_in;
         id_t_ff   <= id_t_in;   id_d_ff   <= id_d_in;   id_u_ff   <= id_u_in;
         cnt_ff    <= cnt_in;
      end
      if (state_ff == ST_TOP) begin
         own_act_ff <= rd_data_ff.active;
         own_dl_ff  <= rd_data_ff.dl;
         own_ul_ff  <= rd_data_ff.ul;
      end
      if (state_ff == ST_FIN && state_in == ST_IDLE)
         rsp_data_ff <= {7'd0, own_ul_ff, own_dl_ff, rd_data_ff.total, act_ff,
                         top_u_ff, top_d_ff, top_t_ff, own_act_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // no item is taken during the clearing pass
   a_no_accept_clr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |-> !req_tready) else $error("accept during clear");
   // the scan index stays inside the scan range
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff >= SCAN_LO && idx_ff <= SCAN_HI))
      else $error("scan index out of range");
   // a sighting writes its own entry, then reads it back
   a_sight_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGHT) |=> (state_ff == ST_OWN && $stable(rnti_ff)))
      else $error("sighting sequence broken");
   // a finished item raises the result
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && state_in == ST_IDLE) |=> rsp_tvalid)
      else $error("result lost");
`endif

endmodule

/* tb/rnti_activity_tracker_core_tb.sv */
module rnti_activity_tracker_core_tb;
   import rat_pkg::*;

   typedef struct packed {
      logic        op;
      logic [15:0] rnti;
      logic [31:0] tti;
      logic        dl;
   } req_item_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;   // rnti[15:0], tti[47:16], is_downlink[48], zero fill
   logic         req_tuser;   // opcode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;   // is_active[0], top_total_rnti[16:1], top_dl_rnti[32:17],
                              // top_ul_rnti[48:33], active_count[64:49],
                              // top_total_count[80:65], own_dl_count[96:81],
                              // own_ul_count[112:97], zero fill
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [30:0]  csr_wdata;

   rnti_activity_tracker_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // activity table shadow
   bit          shd_active [65536];
   bit [15:0]   shd_total [65536];
   bit [15:0]   shd_dl [65536];
   bit [15:0]   shd_ul [65536];
   bit [31:0]   shd_last [65536];
   bit [31:0]   shd_first [65536];
   bit [15:0]   top_total_id, top_dl_id, top_ul_id, active_cnt;
   bit [30:0]   idle_limit, window_len;
   bit [15:0]   count_limit;

   req_item_type    pending_items [$];
   logic [119:0]    expected_rsp [$];
   int              send_idle_pct, stall_pct;
   int              rsp_beats;
   int              hold_left;
   bit              hold_done;
   bit              failed;
   int unsigned     cycle_cnt;

   function automatic bit past_limit(bit [31:0] now, bit [31:0] stamp, bit [30:0] lim);
      bit [31:0] d;
      d = now - stamp;
      return !d[31] && (d[30:0] > lim);
   endfunction

   function automatic bit within_limit(bit [31:0] now, bit [31:0] stamp, bit [30:0] lim);
      bit [31:0] d;
      d = now - stamp;
      return d[31] || (d[30:0] < lim);
   endfunction

   function automatic void wipe_entry(int i);
      shd_active[i] = 0;
      shd_total[i]  = 0;
      shd_dl[i]     = 0;
      shd_ul[i]     = 0;
      shd_last[i]   = 0;
      shd_first[i]  = 0;
   endfunction

   // update the shadow table for one item and return the response it should give
   function automatic logic [119:0] track_activity(req_item_type it);
      int        r;
      int        cnt;
      bit [15:0] bt, bd, bu, it_t, it_d, it_u;
      r = it.rnti;
      if (it.op == OP_SIGHTING) begin
         if (it.dl) shd_dl[r] = shd_dl[r] + 16'd1;
         else shd_ul[r] = shd_ul[r] + 16'd1;
         shd_last[r]  = it.tti;
         shd_total[r] = shd_total[r] + 16'd1;
         if (!shd_active[r]) begin
            if (shd_first[r] == 0)
               shd_first[r] = it.tti;
            else if (within_limit(it.tti, shd_first[r], window_len) &&
                     shd_total[r] > count_limit)
               shd_active[r] = 1;
         end
      end else begin
         // ageing pass, then ranking pass; strict compare keeps lowest rnti
         for (int i = SCAN_FIRST_DEF; i < SCAN_END_DEF; i++) begin
            if (shd_active[i]) begin
               if (past_limit(it.tti, shd_last[i], idle_limit)) wipe_entry(i);
            end else if (shd_total[i] > 0) begin
               if (past_limit(it.tti, shd_first[i], window_len)) wipe_entry(i);
            end
         end
         cnt = 0; bt = 0; bd = 0; bu = 0; it_t = 0; it_d = 0; it_u = 0;
         for (int i = SCAN_FIRST_DEF; i < SCAN_END_DEF; i++) begin
            if (shd_active[i]) cnt++;
            if (shd_total[i] > bt) begin bt = shd_total[i]; it_t = 16'(i); end
            if (shd_dl[i] > bd) begin bd = shd_dl[i]; it_d = 16'(i); end
            if (shd_ul[i] > bu) begin bu = shd_ul[i]; it_u = 16'(i); end
         end
         top_total_id = it_t;
         top_dl_id    = it_d;
         top_ul_id    = it_u;
         active_cnt   = 16'(cnt);
      end
      return {7'd0, shd_ul[r], shd_dl[r], shd_total[top_total_id], active_cnt,
              top_ul_id, top_dl_id, top_total_id, shd_active[r]};
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // driver: accepted beats go to the predictor
   always @(posedge clock) begin
      req_item_type nxt;
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
         req_tuser  <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            expected_rsp.push_back(track_activity({req_tuser, req_tdata[15:0],
                                                   req_tdata[47:16], req_tdata[48]}));
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_items.pop_front();
            req_tvalid <= 1;
            req_tuser  <= nxt.op;
            req_tdata  <= {7'd0, nxt.dl, nxt.tti, nxt.rnti};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // one long receiver hold-off, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && rsp_beats >= 8) begin
         hold_done <= 1;
         hold_left <= 400;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor and receiver back-pressure
   always @(posedge clock) begin
      logic [119:0] exp_v;
      int lo, w;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response beat, actual %h", $realtime, rsp_tdata);
               failed = 1;
            end else begin
               exp_v = expected_rsp.pop_front();
               for (int f = 0; f < 8; f++) begin
                  lo = (f == 0) ? 0 : 1 + 16 * (f - 1);
                  w  = (f == 0) ? 1 : 16;
                  if (((exp_v >> lo) & ((120'd1 << w) - 1)) !=
                      ((rsp_tdata >> lo) & ((120'd1 << w) - 1))) begin
                     $display("%0t: field %0d mismatch, expected %h actual %h", $realtime,
                              f, (exp_v >> lo) & ((120'd1 << w) - 1),
                              (rsp_tdata >> lo) & ((120'd1 << w) - 1));
                     failed = 1;
                  end
               end
            end
         end
         if (hold_left > 0)
            rsp_tready <= 0;
         else
            rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > 6000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [30:0] val);
      @(posedge clock);
      csr_we    <= 1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_INACTIVE_LIMIT:  idle_limit  = val;
         REG_REAPPEAR_WINDOW: window_len  = val;
         default:             count_limit = val[15:0];
      endcase
   endtask

   // sampled away from the rising edge so driver updates have landed
   task automatic settle();
      while (pending_items.size() > 0 || req_tvalid || expected_rsp.size() > 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic add_item(logic op, logic [15:0] r, logic [31:0] t, logic dl);
      pending_items.push_back('{op, r, t, dl});
   endtask

   bit [31:0] now_tti;
   int        tick_cnt;

   // random sightings and occasional ticks, mostly on a small pool of rntis, so entries activate and age
   task automatic random_phase(int n);
      logic [15:0] r;
      logic [31:0] t;
      for (int k = 0; k < n; k++) begin
         now_tti += $urandom_range(0, 40);
         t = ($urandom_range(49) == 0) ? $urandom : now_tti;
         case ($urandom_range(19))
            0:       r = 16'($urandom);
            1:       r = 16'($urandom_range(0, 9));
            2:       r = 16'($urandom_range(65533, 65535));
            default: r = 16'($urandom_range(10, 40));
         endcase
         if (tick_cnt < 9 && $urandom_range(59) == 0) begin
            tick_cnt++;
            add_item(OP_TICK, r, t, 1'($urandom_range(1)));
         end else begin
            add_item(OP_SIGHTING, r, t, 1'($urandom_range(1)));
         end
      end
      // closing tick so the statistics move in every phase
      add_item(OP_TICK, 16'd20, now_tti, 1'b0);
   endtask

   initial begin
      reset      = 1;
      csr_we     = 0;
      csr_addr   = REG_INACTIVE_LIMIT;
      csr_wdata  = '0;
      idle_limit = INACTIVE_LIMIT_RST;
      window_len = REAPPEAR_WINDOW_RST;
      count_limit = REAPPEAR_COUNT_RST;
      send_idle_pct = 0;
      stall_pct  = 0;
      now_tti    = 100;
      repeat (3) @(posedge clock);
      reset <= 0;

      // phase 0: defaults, no idling, directed items first
      write_reg(REG_INACTIVE_LIMIT, INACTIVE_LIMIT_RST);
      write_reg(REG_REAPPEAR_WINDOW, REAPPEAR_WINDOW_RST);
      write_reg(REG_REAPPEAR_COUNT, REAPPEAR_COUNT_RST);
      add_item(OP_SIGHTING, 16'd0, 32'd0, 1'b1);          // tti zero leaves entry unmarked
      add_item(OP_SIGHTING, 16'd0, 32'd5, 1'b0);
      add_item(OP_SIGHTING, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      add_item(OP_SIGHTING, 16'd9, 32'd7, 1'b1);           // just below scan range
      add_item(OP_SIGHTING, 16'd65533, 32'd7, 1'b0);       // just above scan range
      add_item(OP_SIGHTING, 16'd65532, 32'd8, 1'b0);
      for (int k = 0; k < 5; k++)                          // activation past count limit
         add_item(OP_SIGHTING, 16'd10, 32'd20 + k, k[0]);
      add_item(OP_SIGHTING, 16'd200, 32'd30, 1'b1);        // tie on totals
      add_item(OP_SIGHTING, 16'd201, 32'd30, 1'b0);
      add_item(OP_SIGHTING, 16'd300, 32'd50, 1'b1);        // stamp later than tick
      add_item(OP_TICK, 16'd10, 32'd40, 1'b1);
      add_item(OP_SIGHTING, 16'd300, 32'd10, 1'b0);        // negative difference
      add_item(OP_SIGHTING, 16'hAAAA, 32'hAAAA_AAAA, 1'b0);
      add_item(OP_SIGHTING, 16'h5555, 32'h5555_5555, 1'b1);
      add_item(OP_TICK, 16'd300, 32'd3000, 1'b0);          // ages out every scanned entry but 16'h5555
      random_phase(140);
      settle();

      // phase 1: sender idles
      write_reg(REG_INACTIVE_LIMIT, 31'd0);
      write_reg(REG_REAPPEAR_WINDOW, 31'h7FFF_FFFF);
      write_reg(REG_REAPPEAR_COUNT, 31'd0);
      send_idle_pct = 62;
      random_phase(140);
      settle();

      // phase 2: receiver stalls
      write_reg(REG_INACTIVE_LIMIT, 31'h7FFF_FFFF);
      write_reg(REG_REAPPEAR_WINDOW, 31'd0);
      write_reg(REG_REAPPEAR_COUNT, 31'd65535);
      send_idle_pct = 0;
      stall_pct = 62;
      random_phase(140);
      settle();

      // phase 3: both sides idle a little
      write_reg(REG_INACTIVE_LIMIT, 31'd50);
      write_reg(REG_REAPPEAR_WINDOW, 31'd200);
      write_reg(REG_REAPPEAR_COUNT, 31'd2);
      send_idle_pct = 18;
      stall_pct = 18;
      random_phase(140);
      settle();

      repeat (20) @(posedge clock);
      if (!failed && expected_rsp.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hdl/rat_pkg.sv
hdl/rnti_activity_tracker_core.sv
tb/rnti_activity_tracker_core_tb.sv
